// ----- rtl/pcb_pkg.sv -----
// Package for the passive cell balance sequencer.
// It holds the shared types, the phase codes, the register indexes and the reset values.
// It has no dependencies.
package pcb_pkg;

  localparam int MV_W       = 16;  // millivolt fields and registers
  localparam int MS_W       = 32;  // time stamps
  localparam int CELL_IDX_W = 3;   // chosen cell, NO_CELL included
  localparam int MASK_W     = 4;   // bleed mask, one bit per cell port
  localparam int MAX_CELLS  = 4;   // cell voltage ports on the block
  localparam int CFG_IDX_W  = 2;

  localparam logic [CELL_IDX_W-1:0] NO_CELL = 3'd4;

  localparam logic [MV_W-1:0] STOP_SPREAD_RST  = 16'd10;
  localparam logic [MV_W-1:0] START_SPREAD_RST = 16'd30;
  localparam logic [MV_W-1:0] BLEED_ON_RST     = 16'd300;
  localparam logic [MV_W-1:0] REST_RST         = 16'd80;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_BLEED = 2'd1,
    PH_REST  = 2'd2
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STOP_SPREAD  = 2'd0,
    CFG_START_SPREAD = 2'd1,
    CFG_BLEED_ON     = 2'd2,
    CFG_REST         = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [MV_W-1:0] stop_spread_mv;
    logic [MV_W-1:0] start_spread_mv;
    logic [MV_W-1:0] bleed_on_ms;
    logic [MV_W-1:0] rest_ms;
  } cfg_t;

  typedef struct packed {
    phase_t                phase;
    logic [CELL_IDX_W-1:0] chosen;
    logic [MS_W-1:0]       start_ms;
  } pcb_state_t;

  typedef struct packed {
    logic [MASK_W-1:0]     bleed_mask;
    phase_t                phase;
    logic [CELL_IDX_W-1:0] active_cell;
  } pcb_result_t;

endpackage

// ----- rtl/pcb_cfg_regs.sv -----
// Configuration register file of the passive cell balance sequencer.
// It uses pcb_pkg for the register indexes, the reset values and cfg_t.
module pcb_cfg_regs
  import pcb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MV_W-1:0]      cfg_wdata,
  output cfg_t                 cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stop_spread_mv  <= STOP_SPREAD_RST;
      cfg_r.start_spread_mv <= START_SPREAD_RST;
      cfg_r.bleed_on_ms     <= BLEED_ON_RST;
      cfg_r.rest_ms         <= REST_RST;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_STOP_SPREAD:  cfg_r.stop_spread_mv  <= cfg_wdata;
        CFG_START_SPREAD: cfg_r.start_spread_mv <= cfg_wdata;
        CFG_BLEED_ON:     cfg_r.bleed_on_ms     <= cfg_wdata;
        CFG_REST:         cfg_r.rest_ms         <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/pcb_step.sv -----
// Next-state and result logic for one tick of the passive cell balance sequencer.
// It uses pcb_pkg. The logic is combinational and sits between the input and result registers.
module pcb_step
  import pcb_pkg::*;
#(
  parameter int CELLS = 4
) (
  input  logic [MV_W-1:0] cells [CELLS],
  input  logic [MV_W-1:0] pack_min_mv,
  input  logic [MV_W-1:0] pack_spread_mv,
  input  logic [MS_W-1:0] now_ms,
  input  logic            enable,
  input  cfg_t            cfg,
  input  pcb_state_t      st,
  output pcb_state_t      st_nxt,
  output pcb_result_t     res
);

  localparam int IdxW = (CELLS > 1) ? $clog2(CELLS) : 1;

  logic [IdxW-1:0]      best_idx;
  logic [MV_W-1:0]      top_mv;
  logic [MS_W-1:0]      elapsed;
  logic signed [MV_W:0] excess;
  logic                 stop;

  // Highest cell, lowest index wins a tie (strict compare).
  always_comb begin
    best_idx = '0;
    top_mv   = cells[0];
    for (int i = 1; i < CELLS; i++) begin
      if (cells[i] > top_mv) begin
        top_mv   = cells[i];
        best_idx = IdxW'(i);
      end
    end
  end

  assign elapsed = now_ms - st.start_ms;  // wraps mod 2^32
  assign excess  = $signed({1'b0, top_mv}) - $signed({1'b0, pack_min_mv});
  assign stop    = !enable || (pack_spread_mv <= cfg.stop_spread_mv);

  always_comb begin
    st_nxt = st;
    if (stop) begin
      st_nxt.phase  = PH_IDLE;
      st_nxt.chosen = NO_CELL;
    end else begin
      case (st.phase)
        PH_BLEED: begin
          if (elapsed >= {{(MS_W-MV_W){1'b0}}, cfg.bleed_on_ms}) begin
            st_nxt.start_ms = now_ms;
            st_nxt.phase    = PH_REST;
          end
        end
        PH_REST: begin
          if (elapsed >= {{(MS_W-MV_W){1'b0}}, cfg.rest_ms}) begin
            st_nxt.phase = PH_IDLE;
          end
        end
        default: begin
          st_nxt.phase = PH_IDLE;
          if (pack_spread_mv >= cfg.start_spread_mv) begin
            st_nxt.chosen = CELL_IDX_W'(best_idx);
            if (excess >= $signed({1'b0, cfg.start_spread_mv})) begin
              st_nxt.start_ms = now_ms;
              st_nxt.phase    = PH_BLEED;
            end
          end
        end
      endcase
    end
  end

  always_comb begin
    res.bleed_mask  = '0;
    res.phase       = st_nxt.phase;
    res.active_cell = st_nxt.chosen;
    if (st_nxt.phase == PH_BLEED && st_nxt.chosen < NO_CELL) begin
      res.bleed_mask = MASK_W'(1) << st_nxt.chosen[1:0];
    end
  end

endmodule

// ----- rtl/passive_cell_balance_sequencer.sv -----
// Passive cell balance sequencer, top level. One input item is one tick: four cell voltages,
// the pack minimum and spread, the time and an enable. The block answers each tick with one
// result item: the bleed mask, the phase (idle, bleeding, resting) and the chosen cell.
// Throughput is one item per clock while out_ready stays high. An item taken sits in the
// input register, and the tick logic in pcb_step loads its result into the result register
// once that register is empty or being drained. The phase, chosen cell and phase start time
// are updated as the item moves into the result register, so the next item always sees the
// state left by this one. While a result is held (out_ready low), one more item can be taken
// into the input register; after that in_ready drops until out_ready takes the held result.
// The user writes registers through cfg_wr_en/cfg_index/cfg_wdata only while the block is
// idle; the block itself does not enforce this. CELL_COUNT sets how many cell inputs the pick
// looks at (at most the four cell ports); depends on pcb_pkg, pcb_cfg_regs and pcb_step.
module passive_cell_balance_sequencer
  import pcb_pkg::*;
#(
  parameter int CELL_COUNT = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration write port
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [MV_W-1:0]       cfg_wdata,
  // input item channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [MV_W-1:0]       in_cell0_mv,
  input  logic [MV_W-1:0]       in_cell1_mv,
  input  logic [MV_W-1:0]       in_cell2_mv,
  input  logic [MV_W-1:0]       in_cell3_mv,
  input  logic [MV_W-1:0]       in_pack_min_mv,
  input  logic [MV_W-1:0]       in_pack_spread_mv,
  input  logic [MS_W-1:0]       in_now_ms,
  input  logic                  in_enable,
  // result item channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [MASK_W-1:0]     out_bleed_mask,
  output logic [1:0]            out_phase,
  output logic [CELL_IDX_W-1:0] out_active_cell
);

  // Cells actually looked at by the pick.
  localparam int CellsRead = (CELL_COUNT < MAX_CELLS) ? CELL_COUNT : MAX_CELLS;

  cfg_t cfg;

  // Input register stage
  logic            s1_valid_r;
  logic [MV_W-1:0] s1_cell_r [CellsRead];
  logic [MV_W-1:0] s1_min_r;
  logic [MV_W-1:0] s1_spread_r;
  logic [MS_W-1:0] s1_now_r;
  logic            s1_en_r;

  logic [MV_W-1:0] in_cells [MAX_CELLS];

  // Persistent sequencer state
  pcb_state_t  st_r;
  pcb_state_t  st_nxt;
  pcb_result_t res_nxt;

  // Result register stage
  logic        out_valid_r;
  pcb_result_t out_res_r;

  logic in_take;
  logic s1_adv;
  logic s1_fire;

  assign in_cells[0] = in_cell0_mv;
  assign in_cells[1] = in_cell1_mv;
  assign in_cells[2] = in_cell2_mv;
  assign in_cells[3] = in_cell3_mv;

  // Result slot is free when empty or being drained this cycle.
  assign s1_adv   = !out_valid_r || out_ready;
  assign s1_fire  = s1_valid_r && s1_adv;
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_take  = in_valid && in_ready;

  pcb_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pcb_step #(
    .CELLS (CellsRead)
  ) u_step (
    .cells          (s1_cell_r),
    .pack_min_mv    (s1_min_r),
    .pack_spread_mv (s1_spread_r),
    .now_ms         (s1_now_r),
    .enable         (s1_en_r),
    .cfg            (cfg),
    .st             (st_r),
    .st_nxt         (st_nxt),
    .res            (res_nxt)
  );

  // Input stage: control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Input stage: payload, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      for (int i = 0; i < CellsRead; i++) begin
        s1_cell_r[i] <= in_cells[i];
      end
      s1_min_r    <= in_pack_min_mv;
      s1_spread_r <= in_pack_spread_mv;
      s1_now_r    <= in_now_ms;
      s1_en_r     <= in_enable;
    end
  end

  // State commits exactly once per item, when it moves to the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase    <= PH_IDLE;
      st_r.chosen   <= NO_CELL;
      st_r.start_ms <= '0;
    end else if (s1_fire) begin
      st_r <= st_nxt;
    end
  end

  // Result stage: control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  // Result stage: payload
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_bleed_mask  = out_res_r.bleed_mask;
  assign out_phase       = out_res_r.phase;
  assign out_active_cell = out_res_r.active_cell;

endmodule

// ----- rtl/pcb_checker.sv -----
// Port-level checker for the passive cell balance sequencer, with its bind statement.
// It uses pcb_pkg for the phase and cell codes; it sees only the top level's ports.
module pcb_checker
  import pcb_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [MASK_W-1:0]     out_bleed_mask,
  input logic [1:0]            out_phase,
  input logic [CELL_IDX_W-1:0] out_active_cell
);

  // No result may survive a reset.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Bleed only while bleeding.
  a_mask_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_phase != PH_BLEED) |-> out_bleed_mask == '0)
    else $error("bleed on outside the bleeding phase");

  // While bleeding exactly one cell bleeds, and it is a real cell.
  a_bleed_one: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_phase == PH_BLEED) |->
      ($onehot(out_bleed_mask) && out_active_cell != NO_CELL))
    else $error("bleeding without exactly one chosen cell");

  // A stalled result keeps its mask.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_bleed_mask)))
    else $error("stalled result changed");

endmodule

bind passive_cell_balance_sequencer pcb_checker u_pcb_checker (.*);

// ----- tb/tb_passive_cell_balance_sequencer.sv -----
// Self-checking testbench for passive_cell_balance_sequencer: directed ticks, then random ticks,
// each checked field by field against a predictor of the balancing state machine.
// Depends on pcb_pkg and the RTL of the block; needs no files or arguments.
module tb_passive_cell_balance_sequencer;
  timeunit 1ns;
  timeprecision 1ps;

  import pcb_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 9;
  localparam int CELL_COUNT    = 4;
  localparam int CELLS_SEEN    = (CELL_COUNT < MAX_CELLS) ? CELL_COUNT : MAX_CELLS;
  localparam int SETTLE_CYCLES = 4;     // margin after the last result drains
  localparam int STALL_LIMIT   = 3000;  // cycles with no handshake on either channel
  localparam int MAX_REPORTS   = 40;

  // One tick as seen on the input channel.
  typedef struct packed {
    logic [MAX_CELLS-1:0][MV_W-1:0] cell_mv;
    logic [MV_W-1:0]                min_mv;
    logic [MV_W-1:0]                spread_mv;
    logic [MS_W-1:0]                now_ms;
    logic                           enable;
  } tick_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [MV_W-1:0]       cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  logic [MV_W-1:0]       in_cell0_mv;
  logic [MV_W-1:0]       in_cell1_mv;
  logic [MV_W-1:0]       in_cell2_mv;
  logic [MV_W-1:0]       in_cell3_mv;
  logic [MV_W-1:0]       in_pack_min_mv;
  logic [MV_W-1:0]       in_pack_spread_mv;
  logic [MS_W-1:0]       in_now_ms;
  logic                  in_enable;
  logic                  out_valid;
  logic                  out_ready;
  logic [MASK_W-1:0]     out_bleed_mask;
  logic [1:0]            out_phase;
  logic [CELL_IDX_W-1:0] out_active_cell;

  passive_cell_balance_sequencer #(
    .CELL_COUNT(CELL_COUNT)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cell0_mv       (in_cell0_mv),
    .in_cell1_mv       (in_cell1_mv),
    .in_cell2_mv       (in_cell2_mv),
    .in_cell3_mv       (in_cell3_mv),
    .in_pack_min_mv    (in_pack_min_mv),
    .in_pack_spread_mv (in_pack_spread_mv),
    .in_now_ms         (in_now_ms),
    .in_enable         (in_enable),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_bleed_mask    (out_bleed_mask),
    .out_phase         (out_phase),
    .out_active_cell   (out_active_cell)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Balancing predictor: its own copy of the registers and of the sequencer state.
  // ---------------------------------------------------------------------------
  cfg_t                  bal_cfg = '{stop_spread_mv:  STOP_SPREAD_RST,
                                     start_spread_mv: START_SPREAD_RST,
                                     bleed_on_ms:     BLEED_ON_RST,
                                     rest_ms:         REST_RST};
  phase_t                bal_phase    = PH_IDLE;
  logic [CELL_IDX_W-1:0] bal_cell     = NO_CELL;
  logic [MS_W-1:0]       bal_start_ms = '0;

  pcb_result_t expected_results[$];   // one per accepted tick, oldest first

  int unsigned mismatches    = 0;
  int unsigned results_seen  = 0;
  int unsigned stall_cycles  = 0;
  int unsigned send_idle_pct = 17;
  int unsigned recv_idle_pct = 74;
  logic [MS_W-1:0] clock_ms;          // running time for well-formed random ticks

  // Advance the sequencer by one tick and return what the block must answer.
  function automatic pcb_result_t predict_tick(tick_t t);
    logic [MS_W-1:0]       elapsed;
    logic [CELL_IDX_W-1:0] top_idx;
    logic [MV_W-1:0]       top_mv;
    int                    excess;
    int                    i;
    pcb_result_t           r;
    elapsed = t.now_ms - bal_start_ms;  // wraps modulo 2^32
    if (!t.enable || t.spread_mv <= bal_cfg.stop_spread_mv) begin
      bal_phase = PH_IDLE;
      bal_cell  = NO_CELL;              // start time is kept
    end else if (bal_phase == PH_BLEED) begin
      if (elapsed >= MS_W'(bal_cfg.bleed_on_ms)) begin
        bal_start_ms = t.now_ms;
        bal_phase    = PH_REST;
      end
    end else if (bal_phase == PH_REST) begin
      if (elapsed >= MS_W'(bal_cfg.rest_ms))
        bal_phase = PH_IDLE;            // chosen cell kept
    end else begin
      bal_phase = PH_IDLE;
      if (t.spread_mv >= bal_cfg.start_spread_mv) begin
        // highest cell, lowest index wins a tie; stored even if the excess test fails
        top_idx = '0;
        top_mv  = t.cell_mv[0];
        for (i = 1; i < CELLS_SEEN; i++) begin
          if (t.cell_mv[i] > top_mv) begin
            top_mv  = t.cell_mv[i];
            top_idx = CELL_IDX_W'(i);
          end
        end
        bal_cell = top_idx;
        excess   = int'(top_mv) - int'(t.min_mv);   // may go negative
        if (excess >= int'(bal_cfg.start_spread_mv)) begin
          bal_start_ms = t.now_ms;
          bal_phase    = PH_BLEED;
        end
      end
    end
    r.bleed_mask  = (bal_phase == PH_BLEED && bal_cell < MAX_CELLS) ?
                    MASK_W'(1) << bal_cell : '0;
    r.phase       = bal_phase;
    r.active_cell = bal_cell;
    return r;
  endfunction

  function automatic tick_t tick_of(int unsigned c0, int unsigned c1, int unsigned c2,
                                    int unsigned c3, int unsigned min_mv,
                                    int unsigned spread_mv, logic [MS_W-1:0] now_ms,
                                    logic enable);
    tick_t t;
    t.cell_mv[0] = MV_W'(c0);
    t.cell_mv[1] = MV_W'(c1);
    t.cell_mv[2] = MV_W'(c2);
    t.cell_mv[3] = MV_W'(c3);
    t.min_mv     = MV_W'(min_mv);
    t.spread_mv  = MV_W'(spread_mv);
    t.now_ms     = now_ms;
    t.enable     = enable;
    return t;
  endfunction

  // Mostly a consistent pack on a running clock; the rest is noise or a broken pack.
  function automatic tick_t random_tick(int unsigned dev_max, int unsigned step_max);
    tick_t           t;
    logic [MV_W-1:0] lo;
    logic [MV_W-1:0] hi;
    int unsigned     roll;
    int unsigned     base;
    int              i;
    roll = $urandom_range(99);
    if (roll < 12) begin
      for (i = 0; i < MAX_CELLS; i++)
        t.cell_mv[i] = MV_W'($urandom);
      t.min_mv    = MV_W'($urandom);
      t.spread_mv = MV_W'($urandom);
      t.now_ms    = $urandom;
      t.enable    = 1'($urandom_range(1));
      return t;
    end
    base = $urandom_range(65535 - dev_max);
    lo   = '1;
    hi   = '0;
    for (i = 0; i < MAX_CELLS; i++) begin
      t.cell_mv[i] = MV_W'(base + $urandom_range(dev_max));
      if (t.cell_mv[i] < lo) lo = t.cell_mv[i];
      if (t.cell_mv[i] > hi) hi = t.cell_mv[i];
    end
    t.min_mv    = lo;
    t.spread_mv = hi - lo;
    if (roll < 16)
      t.min_mv = MV_W'($urandom);       // minimum that disagrees with the cells
    else if (roll < 20)
      t.spread_mv = MV_W'($urandom_range(int'(bal_cfg.start_spread_mv) + 2));
    // occasional jumps of the clock, some landing just short of the wrap
    roll = $urandom_range(99);
    if (roll < 2)
      clock_ms = $urandom;
    else if (roll < 4)
      clock_ms = 32'hFFFF_FFFF - $urandom_range(step_max * 4);
    clock_ms += $urandom_range(step_max);
    t.now_ms = clock_ms;
    t.enable = ($urandom_range(49) != 0);
    return t;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: one tick per call. in_valid stays high into the next call unless a gap is
  // taken, so it is never lowered and raised in the same step.
  // ---------------------------------------------------------------------------
  task automatic send_tick(tick_t t);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid          <= 1'b1;
    in_cell0_mv       <= t.cell_mv[0];
    in_cell1_mv       <= t.cell_mv[1];
    in_cell2_mv       <= t.cell_mv[2];
    in_cell3_mv       <= t.cell_mv[3];
    in_pack_min_mv    <= t.min_mv;
    in_pack_spread_mv <= t.spread_mv;
    in_now_ms         <= t.now_ms;
    in_enable         <= t.enable;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_results.push_back(predict_tick(t));
  endtask

  // Stop sending and let every outstanding result drain out of the block.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [MV_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      CFG_STOP_SPREAD:  bal_cfg.stop_spread_mv  = value;
      CFG_START_SPREAD: bal_cfg.start_spread_mv = value;
      CFG_BLEED_ON:     bal_cfg.bleed_on_ms     = value;
      CFG_REST:         bal_cfg.rest_ms         = value;
      default: ;
    endcase
  endtask

  // All four registers, written back to back while the block is idle.
  task automatic set_config(int unsigned stop_mv, int unsigned start_mv,
                            int unsigned bleed_ms, int unsigned rest_time_ms);
    wait_quiet();
    write_reg(CFG_STOP_SPREAD,  MV_W'(stop_mv));
    write_reg(CFG_START_SPREAD, MV_W'(start_mv));
    write_reg(CFG_BLEED_ON,     MV_W'(bleed_ms));
    write_reg(CFG_REST,         MV_W'(rest_time_ms));
    cfg_wr_en <= 1'b0;
  endtask

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("[%0t] result %0d: %s got %0d, expected %0d", $realtime, results_seen, what,
               got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver and result check. out_ready is redrawn each cycle from the idle profile.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin : result_check
        pcb_result_t want;
        if (expected_results.size() == 0) begin
          report_mismatch("result with no tick pending, phase", out_phase, 0);
        end else begin
          want = expected_results.pop_front();
          if (out_bleed_mask !== want.bleed_mask)
            report_mismatch("bleed_mask", out_bleed_mask, want.bleed_mask);
          if (out_phase !== want.phase)
            report_mismatch("phase", out_phase, want.phase);
          if (out_active_cell !== want.active_cell)
            report_mismatch("active_cell", out_active_cell, want.active_cell);
        end
        results_seen++;
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: any handshake resets the count.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values of the registers (stop 10, start 30, bleed 300, rest 80).
  task automatic test_default_sequence();
    send_tick(tick_of(65535, 65535, 65535, 65535, 65535, 65535, 32'hFFFF_FFFF, 1'b0)); // disabled
    send_tick(tick_of(1000, 1010, 1000, 1000, 1000, 10, 50, 1'b1));    // spread at stop
    send_tick(tick_of(1000, 1020, 1000, 1000, 1000, 20, 60, 1'b1));    // below start, still no cell
    send_tick(tick_of(1000, 1050, 1050, 1000, 1000, 50, 100, 1'b1));   // tie: cell 1 bleeds
    send_tick(tick_of(1000, 1050, 1050, 1000, 1000, 50, 399, 1'b1));   // one ms short
    send_tick(tick_of(1000, 1050, 1050, 1000, 1000, 50, 400, 1'b1));   // bleed over, rest
    send_tick(tick_of(1000, 1050, 1050, 1000, 1000, 50, 479, 1'b1));
    send_tick(tick_of(1000, 1050, 1050, 1000, 1000, 50, 480, 1'b1));   // rest over, cell kept
    send_tick(tick_of(3000, 3010, 3020, 3025, 3000, 25, 490, 1'b1));   // idle below start
    send_tick(tick_of(2000, 2010, 2020, 2029, 2000, 40, 500, 1'b1));   // excess one short
    send_tick(tick_of(100, 50, 60, 70, 200, 100, 510, 1'b1));          // negative excess
    send_tick(tick_of(65535, 0, 65535, 0, 0, 65535, 32'hFFFF_FF00, 1'b1));
    send_tick(tick_of(65535, 0, 65535, 0, 0, 65535, 32'h0000_0010, 1'b1)); // wrapped, 272 ms
    send_tick(tick_of(65535, 0, 65535, 0, 0, 65535, 32'h0000_002C, 1'b1)); // 300 ms: rest
    send_tick(tick_of(65535, 0, 65535, 0, 0, 65535, 32'h0000_0030, 1'b0)); // disable in rest
    send_tick(tick_of(0, 0, 0, 0, 0, 65535, 0, 1'b1));                 // no excess, cell 0 kept
    send_tick(tick_of(65535, 65535, 65535, 65535, 0, 65535, 10, 1'b1));
    send_tick(tick_of(10, 20, 40000, 39999, 10, 39990, 20, 1'b1));     // no re-pick while bleeding
    send_tick(tick_of(10, 20, 21, 15, 10, 11, 30, 1'b1));              // just above stop
  endtask

  // Zero thresholds and zero times: each phase lasts exactly one tick.
  task automatic test_zero_times();
    set_config(0, 0, 0, 0);
    send_tick(tick_of(500, 500, 500, 500, 500, 0, 7, 1'b1));           // spread 0 stops
    send_tick(tick_of(500, 500, 500, 500, 500, 1, 7, 1'b1));           // zero excess bleeds
    send_tick(tick_of(500, 500, 500, 500, 500, 1, 7, 1'b1));           // rest
    send_tick(tick_of(500, 500, 500, 500, 500, 1, 7, 1'b1));           // idle
    send_tick(tick_of(1, 2, 3, 4, 1, 3, 8, 1'b1));                     // cell 3
    send_tick(tick_of(1, 2, 3, 4, 1, 3, 8, 1'b1));
  endtask

  // Largest register values.
  task automatic test_register_extremes();
    set_config(0, 65535, 65535, 65535);
    send_tick(tick_of(0, 65535, 65535, 0, 0, 65535, 5, 1'b1));         // excess exactly 65535
    send_tick(tick_of(0, 65535, 65535, 0, 0, 65535, 65539, 1'b1));
    send_tick(tick_of(0, 65535, 65535, 0, 0, 65535, 65540, 1'b1));     // rest
    send_tick(tick_of(0, 65535, 65535, 0, 0, 65535, 131074, 1'b1));
    send_tick(tick_of(0, 65535, 65535, 0, 0, 65535, 131075, 1'b1));    // idle
    send_tick(tick_of(0, 65534, 0, 0, 0, 65534, 131080, 1'b1));        // spread below start
    set_config(65535, 65535, 65535, 65535);
    send_tick(tick_of(65535, 0, 0, 0, 0, 65535, 0, 1'b1));             // every spread stops
  endtask

  task automatic test_random_slow_receiver();
    int unsigned stop_mv;
    stop_mv = $urandom_range(20);
    set_config(stop_mv, $urandom_range(20, 120), $urandom_range(300), $urandom_range(120));
    send_idle_pct = 17;
    recv_idle_pct = 74;
    clock_ms = $urandom;
    repeat (310) send_tick(random_tick(180, 40));
  endtask

  task automatic test_random_slow_sender();
    set_config($urandom_range(200), $urandom_range(100, 1500), $urandom_range(500, 3000),
               $urandom_range(1000));
    send_idle_pct = 74;
    recv_idle_pct = 17;
    repeat (310) send_tick(random_tick(2500, 400));
  endtask

  task automatic test_random_full_rate();
    set_config(STOP_SPREAD_RST, START_SPREAD_RST, BLEED_ON_RST, REST_RST);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (310) send_tick(random_tick(120, 25));
  endtask

  initial begin
    rst_n             <= 1'b0;
    cfg_wr_en         <= 1'b0;
    cfg_index         <= CFG_STOP_SPREAD;
    cfg_wdata         <= '0;
    in_valid          <= 1'b0;
    in_cell0_mv       <= '0;
    in_cell1_mv       <= '0;
    in_cell2_mv       <= '0;
    in_cell3_mv       <= '0;
    in_pack_min_mv    <= '0;
    in_pack_spread_mv <= '0;
    in_now_ms         <= '0;
    in_enable         <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_sequence();
    test_zero_times();
    test_register_extremes();
    test_random_slow_receiver();
    test_random_slow_sender();
    test_random_full_rate();

    wait_quiet();
    if (expected_results.size() != 0)
      report_mismatch("results never delivered", 0, expected_results.size());
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
